[hw/rtl/hcbp_pkg.sv]
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

  localparam int CODE_W = 32;
  localparam int LEN_W = 6;
  localparam int SYM_W = 8;
  localparam int BYTE_W = 8;
  localparam int WIN_W = CODE_W + BYTE_W;
  localparam int CNT_W = 3;
  localparam int SUM_W = 6;

  localparam int MAX_CODE_LEN = 32;
  localparam int DEFAULT_ALPHABET_SIZE = 256;
  localparam int CODE_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  typedef logic [1:0] op_t;
  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_ENCODE = 2'd1;
  localparam op_t OP_FLUSH = 2'd2;

  typedef struct packed {
    logic              go;
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } pack_req_t;

endpackage

[hw/rtl/huffman_code_bit_packer.sv]
// Top level of the Huffman code bit packer: request decode, code table and packer.
//
// Usage: requests arrive on the input channel (valid, stall, op, symbol,
// code_value, code_length); packed bytes leave on the output channel
// (out_valid, out_stall, out_byte, last_byte). A write request stores a code
// and its length for one symbol. An encode request looks the symbol up and
// appends its code bits, earliest bit first, to the pending byte; each full
// byte is sent out. A flush request sends the padded partial byte, if any.
// The block handles one request at a time. An encode passes through accept,
// table read and window load, then sends one byte per cycle while the
// receiver does not stall, up to four bytes, and then settles; a flush loads
// the window when it is accepted, sends a byte if there is one, and settles.
// The code table RAM has a registered read.
// Reset clears the pending bits and empties the output register; the code
// table holds nothing defined until written. While the receiver stalls, the
// current byte holds in the output register and the packer waits; input
// requests are stalled until the current request has finished.
module huffman_code_bit_packer #(
  parameter int ALPHABET_SIZE = hcbp_pkg::DEFAULT_ALPHABET_SIZE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  hcbp_pkg::op_t               op,
  input  logic [hcbp_pkg::SYM_W-1:0]  symbol,
  input  logic [hcbp_pkg::CODE_W-1:0] code_value,
  input  logic [hcbp_pkg::LEN_W-1:0]  code_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0] out_byte,
  output logic                        last_byte
);
  import hcbp_pkg::*;

  localparam int ADDR_W = $clog2(ALPHABET_SIZE);
  localparam int ENTRY_W = CODE_W + LEN_W;

  typedef enum logic [1:0] {IDLE, LOOKUP, PACK} state_t;

  state_t state;
  logic accept;
  logic sym_ok;
  logic ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  pack_req_t req;
  logic busy;

  assign in_stall = (state != IDLE);
  assign accept = in_valid && !in_stall;
  assign sym_ok = ({1'b0, symbol} < (SYM_W + 1)'(ALPHABET_SIZE));
  assign ram_we = accept && (op == OP_WRITE) && sym_ok;

  always_comb begin
    req.go = 1'b0;
    req.flush = 1'b0;
    req.code = ram_rdata[ENTRY_W-1 -: CODE_W];
    req.len = ram_rdata[LEN_W-1:0];
    if (state == LOOKUP) begin
      req.go = 1'b1;
    end else if (accept && (op == OP_FLUSH)) begin
      req.go = 1'b1;
      req.flush = 1'b1;
    end
  end

  hcbp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ALPHABET_SIZE)
  ) u_code_ram (
    .clk(clk),
    .we(ram_we),
    .addr(symbol[ADDR_W-1:0]),
    .wdata({code_value, code_length}),
    .rdata(ram_rdata)
  );

  hcbp_packer u_packer (
    .clk(clk),
    .rst(rst),
    .req(req),
    .busy(busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .last_byte(last_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            case (op)
              OP_ENCODE: if (sym_ok) state <= LOOKUP;
              OP_FLUSH: state <= PACK;
              default: state <= IDLE;
            endcase
          end
        end
        LOOKUP: begin
          state <= PACK;
        end
        PACK: begin
          if (!busy) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/hcbp_ram.sv]
// Generic single-port synchronous RAM with registered read data.
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hw/rtl/hcbp_packer.sv]
// Bit window, pending byte and byte emitter of the code bit packer.
module hcbp_packer (
  input  logic                         clk,
  input  logic                         rst,
  input  hcbp_pkg::pack_req_t          req,
  output logic                         busy,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]  out_byte,
  output logic                         last_byte
);
  import hcbp_pkg::*;

  logic [BYTE_W-1:0] pending_byte;
  logic [CNT_W-1:0]  pending_count;
  logic [WIN_W-1:0]  window;
  logic [SUM_W-1:0]  total;

  logic [LEN_W-1:0]  len_sat;
  logic [CODE_W-1:0] code_mask;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  shamt;
  logic [WIN_W-1:0]  window_next;
  logic [SUM_W-1:0]  total_next;
  logic              out_free;
  logic              emit;

  always_comb begin
    len_sat = (req.len > LEN_W'(CODE_LIMIT)) ? LEN_W'(CODE_LIMIT) : req.len;
    code_mask = CODE_W'(~({(2*CODE_W){1'b1}} << len_sat));
    sum = SUM_W'(pending_count) + SUM_W'(len_sat);
    shamt = SUM_W'(WIN_W) - sum;
    if (req.flush) begin
      window_next = {pending_byte, {CODE_W{1'b0}}};
      total_next = (pending_count != '0) ? SUM_W'(BYTE_W) : '0;
    end else begin
      window_next = {pending_byte, {CODE_W{1'b0}}} |
                    ({{BYTE_W{1'b0}}, req.code & code_mask} << shamt);
      total_next = sum;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign emit = busy && (total >= SUM_W'(BYTE_W)) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      pending_byte <= '0;
      pending_count <= '0;
    end else begin
      out_valid <= emit || (out_valid && out_stall);
      if (!busy) begin
        if (req.go) begin
          window <= window_next;
          total <= total_next;
          busy <= 1'b1;
        end
      end else if (total >= SUM_W'(BYTE_W)) begin
        if (out_free) begin
          out_byte <= window[WIN_W-1 -: BYTE_W];
          last_byte <= (total < SUM_W'(2 * BYTE_W));
          window <= window << BYTE_W;
          total <= total - SUM_W'(BYTE_W);
        end
      end else begin
        pending_byte <= window[WIN_W-1 -: BYTE_W];
        pending_count <= total[CNT_W-1:0];
        busy <= 1'b0;
      end
    end
  end

endmodule

[test/tb_huffman_code_bit_packer.sv]
// Self-checking testbench for the Huffman code bit packer with a local packing predictor.
module tb_huffman_code_bit_packer;
  import hcbp_pkg::*;

  localparam op_t OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_REQUESTS = 350;
  localparam int DUE_DEPTH = 1024;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              fin;
  } packed_out_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  op_t               op = OP_FLUSH;
  logic [SYM_W-1:0]  symbol = '0;
  logic [CODE_W-1:0] code_value = '0;
  logic [LEN_W-1:0]  code_length = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              last_byte;

  logic [CODE_W-1:0] tbl_code [256];
  logic [LEN_W-1:0]  tbl_len [256];
  bit                tbl_set [256];
  logic [SYM_W-1:0]  written_syms [256];
  int                written_count = 0;
  logic [BYTE_W-1:0] acc_byte = '0;
  int                acc_bits = 0;
  packed_out_t       bytes_due [DUE_DEPTH];
  int                due_wr = 0;
  int                due_rd = 0;
  int                errors = 0;
  bit                calm = 1'b0;
  bit                stall_on = 1'b0;
  int                stall_left = 0;

  huffman_code_bit_packer u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .symbol     (symbol),
    .code_value (code_value),
    .code_length(code_length),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .last_byte  (last_byte)
  );

  always #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return LEN_W'($urandom_range(1, 12));
    end
    if (r < 85) begin
      return LEN_W'($urandom_range(13, 32));
    end
    return LEN_W'($urandom_range(0, 63));
  endfunction

  task automatic add_due(logic [BYTE_W-1:0] d, logic f);
    bytes_due[due_wr % DUE_DEPTH] = '{d, f};
    due_wr++;
  endtask

  task automatic predict_packing(op_t o, logic [SYM_W-1:0] s, logic [CODE_W-1:0] v,
                                 logic [LEN_W-1:0] l);
    int n;
    int start_wr;
    case (o)
      OP_WRITE: begin
        tbl_code[s] = v;
        tbl_len[s] = l;
        if (!tbl_set[s]) begin
          written_syms[written_count] = s;
          written_count++;
        end
        tbl_set[s] = 1'b1;
      end
      OP_ENCODE: begin
        start_wr = due_wr;
        n = (tbl_len[s] > CODE_LIMIT) ? CODE_LIMIT : tbl_len[s];
        for (int i = n - 1; i >= 0; i--) begin
          acc_byte[7 - acc_bits] = tbl_code[s][i];
          acc_bits++;
          if (acc_bits == 8) begin
            add_due(acc_byte, 1'b0);
            acc_byte = '0;
            acc_bits = 0;
          end
        end
        if (due_wr > start_wr) begin
          bytes_due[(due_wr - 1) % DUE_DEPTH].fin = 1'b1;
        end
      end
      OP_FLUSH: begin
        if (acc_bits != 0) begin
          add_due(acc_byte, 1'b1);
        end
        acc_byte = '0;
        acc_bits = 0;
      end
      default: ;
    endcase
  endtask

  task automatic send_request(op_t o, logic [SYM_W-1:0] s, logic [CODE_W-1:0] v,
                              logic [LEN_W-1:0] l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    symbol <= s;
    code_value <= v;
    code_length <= l;
    do @(posedge clk); while (in_stall);
    predict_packing(o, s, v, l);
  endtask

  always @(posedge clk) begin
    if (calm) begin
      stall_on = 1'b0;
      stall_left = 0;
    end else if (stall_left == 0) begin
      stall_on = ($urandom_range(0, 99) < 35);
      if (!stall_on) begin
        stall_left = $urandom_range(1, 10);
      end else if ($urandom_range(0, 99) < 85) begin
        stall_left = $urandom_range(1, 3);
      end else begin
        stall_left = $urandom_range(8, 30);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= stall_on;
  end

  always @(posedge clk) begin : check_bytes
    packed_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_wr == due_rd) begin
        $error("unexpected byte: out_byte %02h last_byte %0b", out_byte, last_byte);
        errors++;
      end else begin
        want = bytes_due[due_rd % DUE_DEPTH];
        due_rd++;
        if (out_byte !== want.data) begin
          $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
          errors++;
        end
        if (last_byte !== want.fin) begin
          $error("last_byte: expected %0b, actual %0b", want.fin, last_byte);
          errors++;
        end
      end
    end
  end

  task automatic test_flush_and_unused();
    send_request(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send_request(OP_UNUSED, 8'h00, 32'h0, 6'd0);
  endtask

  task automatic test_code_extremes();
    send_request(OP_WRITE, 8'h00, 32'hFFFF_FFFF, 6'd32);
    send_request(OP_WRITE, 8'hFF, 32'h0000_0000, 6'd32);
    send_request(OP_WRITE, 8'h01, $urandom, 6'd0);
    send_request(OP_WRITE, 8'h02, 32'h8000_0001, 6'd1);
    send_request(OP_WRITE, 8'h03, 32'hA5A5_5A5A, 6'd63);
    send_request(OP_WRITE, 8'h04, 32'h1234_5678, 6'd33);
    send_request(OP_WRITE, 8'h05, 32'h0000_007F, 6'd7);
    send_request(OP_WRITE, 8'h06, 32'h0000_002A, 6'd6);
    send_request(OP_ENCODE, 8'h01, 32'hFFFF_FFFF, 6'h3F);
    send_request(OP_ENCODE, 8'h02, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'h00, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'h05, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'h05, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'h00, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'h03, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'h04, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'h06, 32'h0, 6'd0);
    send_request(OP_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send_request(OP_FLUSH, 8'h00, 32'h0, 6'd0);
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    send_request(OP_WRITE, 8'h10, 32'h0000_0155, 6'd9);
    send_request(OP_WRITE, 8'h11, 32'h0000_0003, 6'd2);
    repeat (6) begin
      send_request(OP_ENCODE, 8'h10, $urandom, LEN_W'($urandom));
      send_request(OP_ENCODE, 8'h00, $urandom, LEN_W'($urandom));
      send_request(OP_ENCODE, 8'h11, $urandom, LEN_W'($urandom));
    end
    send_request(OP_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
    calm = 1'b0;
  endtask

  task automatic test_random_stream();
    int sent;
    int lo;
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      calm = ($urandom_range(0, 9) == 0);
      lo = (written_count < 16) ? 2 : 0;
      repeat ($urandom_range(lo, 4)) begin
        send_request(OP_WRITE, SYM_W'($urandom_range(0, 255)), $urandom, pick_length());
        sent++;
      end
      repeat ($urandom_range(1, 20)) begin
        if ($urandom_range(0, 19) == 0) begin
          send_request(OP_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
        end else begin
          send_request(OP_ENCODE, written_syms[$urandom_range(0, written_count - 1)],
                       $urandom, LEN_W'($urandom));
          sent++;
        end
      end
      if ($urandom_range(0, 9) < 8) begin
        send_request(OP_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_flush_and_unused();
    test_code_extremes();
    test_back_to_back();
    test_random_stream();
    in_valid <= 1'b0;
    while (due_rd != due_wr) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
